/* hdl/nmt_pkg.sv */
// Shared types and constants for the 3x3 neighbourhood mean threshold block.
package nmt_pkg;

    localparam int SIDE_W = 11;
    localparam int CNT_W  = 2 * SIDE_W;

    localparam logic [SIDE_W-1:0] SIDE_RESET  = 11'd512;
    localparam logic [CNT_W-1:0]  TOTAL_RESET = 22'd262144;

    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } border_t;

    typedef struct packed {
        logic    give;
        logic    last;
        border_t border;
    } item_ctl_t;

endpackage

/* hdl/nmt_ram.sv */
// Generic simple dual-port RAM with registered read.
module nmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/nmt_ctrl.sv */
// Frame counters, side register and per-transaction push/result decisions.
module nmt_ctrl import nmt_pkg::*; #(
    parameter int MAX_SIDE = 1024,
    localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [SIDE_W-1:0] cfg_data,
    input  logic              accept,
    input  logic              drain,
    output logic              push,
    output logic [ADDR_W-1:0] col,
    output item_ctl_t         ctl
);

    localparam int CMP_W = ((ADDR_W > SIDE_W) ? ADDR_W : SIDE_W) + 1;

    logic [SIDE_W-1:0] side_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  taken_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [SIDE_W-1:0] res_col_reg;
    logic [SIDE_W-1:0] res_row_reg;

    logic [SIDE_W-1:0] side_next;
    logic [CNT_W-1:0]  total_next;
    logic              full;
    logic              give;
    logic              last;
    logic              col_wrap;
    logic              res_col_end;
    logic              res_row_end;

    always_comb begin
        if (cfg_data == '0) begin
            side_next = SIDE_W'(1);
        end else if (32'(cfg_data) > MAX_SIDE) begin
            side_next = SIDE_W'(MAX_SIDE);
        end else begin
            side_next = cfg_data;
        end
        total_next = CNT_W'(side_next) * CNT_W'(side_next);
    end

    always_comb begin
        full        = taken_reg >= total_reg;
        push        = drain ? full : !full;
        give        = push && (taken_reg >= (CNT_W'(side_reg) + CNT_W'(1)));
        res_col_end = ((SIDE_W+1)'(res_col_reg) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(side_reg);
        res_row_end = ((SIDE_W+1)'(res_row_reg) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(side_reg);
        last        = give && res_col_end && res_row_end;
        col_wrap    = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(side_reg);
        col         = col_reg;
        ctl.give       = give;
        ctl.last       = last;
        ctl.border.top = res_row_reg != '0;
        ctl.border.bot = !res_row_end;
        ctl.border.lft = res_col_reg != '0;
        ctl.border.rgt = !res_col_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg    <= SIDE_RESET;
            total_reg   <= TOTAL_RESET;
            taken_reg   <= '0;
            col_reg     <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end else if (cfg_valid) begin
            side_reg    <= side_next;
            total_reg   <= total_next;
            taken_reg   <= '0;
            col_reg     <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end else if (accept && push) begin
            if (last) begin
                taken_reg   <= '0;
                col_reg     <= '0;
                res_col_reg <= '0;
                res_row_reg <= '0;
            end else begin
                taken_reg <= taken_reg + CNT_W'(1);
                col_reg   <= col_wrap ? '0 : col_reg + ADDR_W'(1);
                if (give) begin
                    if (res_col_end) begin
                        res_col_reg <= '0;
                        res_row_reg <= res_row_reg + SIDE_W'(1);
                    end else begin
                        res_col_reg <= res_col_reg + SIDE_W'(1);
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= total_reg + CNT_W'(side_reg))
        else $error("push count beyond frame plus drain");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CMP_W'(col_reg) < CMP_W'(side_reg)) && (res_col_reg < side_reg)
        && (res_row_reg < side_reg))
        else $error("column or result position out of frame");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && push && last && !cfg_valid |=> taken_reg == '0 && col_reg == '0)
        else $error("frame did not restart after final result");
`endif

endmodule

/* hdl/nmt_window.sv */
// Row store read-modify-write with forwarding, and the 3x3 window registers.
module nmt_window import nmt_pkg::*; #(
    parameter int MAX_SIDE   = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_push,
    input  logic [ADDR_W-1:0]            in_col,
    input  logic [PIXEL_BITS-1:0]        in_pixel,
    input  item_ctl_t                    in_ctl,
    output logic                         out_valid,
    output item_ctl_t                    out_ctl,
    output logic [8:0][PIXEL_BITS-1:0]   win
);

    logic                       s1_valid_reg;
    logic [ADDR_W-1:0]          s1_col_reg;
    logic [PIXEL_BITS-1:0]      s1_pix_reg;
    item_ctl_t                  s1_ctl_reg;
    logic                       fwd_reg;
    logic [PIXEL_BITS-1:0]      fwd_up_reg;
    logic [PIXEL_BITS-1:0]      fwd_mid_reg;
    logic                       s2_valid_reg;
    item_ctl_t                  s2_ctl_reg;
    logic [8:0][PIXEL_BITS-1:0] win_reg;
    logic [8:0][PIXEL_BITS-1:0] win_next;

    logic [2*PIXEL_BITS-1:0]    rd_data;
    logic [PIXEL_BITS-1:0]      up_eff;
    logic [PIXEL_BITS-1:0]      mid_eff;
    logic                       wr_en;

    assign wr_en = s1_valid_reg && adv;

    nmt_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_rows (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_col_reg),
        .wdata ({mid_eff, s1_pix_reg}),
        .re    (in_push),
        .raddr (in_col),
        .rdata (rd_data)
    );

    always_comb begin
        up_eff  = fwd_reg ? fwd_up_reg  : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
        mid_eff = fwd_reg ? fwd_mid_reg : rd_data[PIXEL_BITS-1:0];
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = up_eff;
        win_next[5] = mid_eff;
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else if (adv) begin
            s1_valid_reg <= in_push;
            fwd_reg      <= s1_valid_reg && in_push && (s1_col_reg == in_col);
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.give;
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_col_reg  <= in_col;
            s1_pix_reg  <= in_pixel;
            s1_ctl_reg  <= in_ctl;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_pix_reg;
            s2_ctl_reg  <= s1_ctl_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_ctl   = s2_ctl_reg;
    assign win       = win_reg;

endmodule

/* hdl/nmt_judge.sv */
// Clipped neighbourhood sum, scaled centre, compare and output register.
module nmt_judge import nmt_pkg::*; #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  item_ctl_t                  in_ctl,
    input  logic [8:0][PIXEL_BITS-1:0] win,
    output logic                       out_valid,
    output logic                       out_above,
    output logic                       out_last
);

    localparam int SUM_W = PIXEL_BITS + 4;

    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [1:0]       row_cnt;
    logic [1:0]       col_cnt;
    logic [3:0]       count;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] scaled;

    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    logic [SUM_W-1:0] s3_scaled_reg;
    logic             out_valid_reg;
    logic             out_above_reg;
    logic             out_last_reg;

    always_comb begin
        row_ok  = {in_ctl.border.bot, 1'b1, in_ctl.border.top};
        col_ok  = {in_ctl.border.rgt, 1'b1, in_ctl.border.lft};
        row_cnt = 2'd1 + 2'(in_ctl.border.top) + 2'(in_ctl.border.bot);
        col_cnt = 2'd1 + 2'(in_ctl.border.lft) + 2'(in_ctl.border.rgt);
        count   = 4'(row_cnt) * 4'(col_cnt);
        sum     = '0;
        for (int i = 0; i < 9; i++) begin
            if (row_ok[i/3] && col_ok[i%3]) begin
                sum = sum + SUM_W'(win[i]);
            end
        end
        scaled = SUM_W'(win[4]) * SUM_W'(count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg  <= in_valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_last_reg   <= in_ctl.last;
            s3_sum_reg    <= sum;
            s3_scaled_reg <= scaled;
            out_above_reg <= s3_scaled_reg > s3_sum_reg;
            out_last_reg  <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_above = out_above_reg;
    assign out_last  = out_last_reg;

endmodule

/* hdl/neighborhood_mean_threshold_3x3_top.sv */
// A result passes the stage-1, window, sum and output registers on its way to m_.
// Throughput: one transaction per cycle unless m_ stalls; the row store is one RAM, read
// on acceptance, written back from stage 1, forwarded if consecutive pushes share a column.
// A result is due once the pixel one row and one column further has been taken.
// Reset: aresetn is synchronous, active low; side returns to 512 and the frame restarts.
// Top level of the 3x3 neighbourhood mean threshold block.
module neighborhood_mean_threshold_3x3_top import nmt_pkg::*; #(
    parameter int MAX_SIDE   = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIDE_W-1:0] cfg_data,    // side_length
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,     // pixel
    input  logic              s_tuser,     // action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,     // above_mean
    output logic              m_tlast
);

    localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic                       adv;
    logic                       accept;
    logic                       push;
    logic [ADDR_W-1:0]          col;
    item_ctl_t                  ctl;
    logic                       win_valid;
    item_ctl_t                  win_ctl;
    logic [8:0][PIXEL_BITS-1:0] win;
    logic                       above;

    assign cfg_ready = 1'b1;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;

    nmt_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .drain     (s_tuser),
        .push      (push),
        .col       (col),
        .ctl       (ctl)
    );

    nmt_window #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_push   (accept && push),
        .in_col    (col),
        .in_pixel  (s_tuser ? '0 : s_tdata[PIXEL_BITS-1:0]),
        .in_ctl    (ctl),
        .out_valid (win_valid),
        .out_ctl   (win_ctl),
        .win       (win)
    );

    nmt_judge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (win_valid),
        .in_ctl    (win_ctl),
        .win       (win),
        .out_valid (m_tvalid),
        .out_above (above),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'b0, above};

endmodule
